// ===== rtl/core/lkv_pkg.sv =====
// Shared types and codes for the LRU key-value cache.
package lkv_pkg;

  localparam int unsigned CFG_W = 5;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE        = 7'b0000001,
    ST_SCAN        = 7'b0000010,
    ST_SCAN_TAIL   = 7'b0000100,
    ST_DECIDE      = 7'b0001000,
    ST_UPDATE      = 7'b0010000,
    ST_UPDATE_TAIL = 7'b0100000,
    ST_DONE        = 7'b1000000
  } state_e;

endpackage

// ===== rtl/core/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
//
// Requests enter on the s_axis channel: tuser carries the request kind (get or
// put), tdata the key and the value. Each request yields exactly one beat on
// m_axis: tuser flags hit and eviction, tdata the read value and evicted key.
// The configuration channel writes the capacity in use; a write while the
// cache holds any entry leaves the capacity unchanged, zero counts as one and
// values above ENTRIES saturate.
// A request walks the entry store through one compare and update unit:
// a lookup pass that reads one entry per cycle (key match, free slot, oldest
// entry), then, for a put or a get hit, a pass that rewrites recency ranks one
// entry per cycle and installs the target entry; a get miss skips the second
// pass. s_axis_tready is low while a request is in flight, so a new request is
// taken only once the previous result has moved to the output register. The
// result sits in an output register: the next request is taken while that beat
// waits, and a stalled receiver holds the block only when a further result is
// ready to leave.
// Reset empties the cache, sets the capacity to min(16, ENTRIES), drops any beat.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lkv_pkg::CFG_W-1:0]   cfg_data_i,     // capacity_in_use
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // req_key, req_value, zero pad
  input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                        s_axis_tuser,   // req_type
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // read_value, evicted_key, zero pad
  output logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic [1:0]                  m_axis_tuser    // hit, evicted
);
  import lkv_pkg::*;

  localparam int unsigned DATA_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned RANK_W  = $clog2(ENTRIES);
  localparam int unsigned CAP_W   = $clog2(ENTRIES + 1);
  localparam int unsigned ENT_W   = KEY_BITS + VALUE_BITS + RANK_W;
  localparam int unsigned CAP_RST = (ENTRIES < 16) ? ENTRIES : 16;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [RANK_W-1:0]     rank;
  } entry_t;

  state_e                state_q;
  logic [IDX_W-1:0]      idx_q;
  logic [IDX_W-1:0]      chk_q;
  logic                  pend_q;
  logic [ENTRIES-1:0]    valid_q;
  logic [CAP_W-1:0]      occ_q;
  logic [CAP_W-1:0]      cap_q;

  logic                  req_put_q;
  logic [KEY_BITS-1:0]   req_key_q;
  logic [VALUE_BITS-1:0] req_value_q;

  logic                  hit_q;
  logic [IDX_W-1:0]      hit_slot_q;
  logic [RANK_W-1:0]     hit_rank_q;
  logic [VALUE_BITS-1:0] hit_value_q;
  logic                  free_q;
  logic [IDX_W-1:0]      free_slot_q;
  logic                  worst_q;
  logic [IDX_W-1:0]      worst_slot_q;
  logic [RANK_W-1:0]     worst_rank_q;
  logic [KEY_BITS-1:0]   worst_key_q;

  logic [IDX_W-1:0]      slot_q;
  logic [RANK_W-1:0]     old_rank_q;
  logic                  age_all_q;

  logic                  res_hit_q;
  logic [VALUE_BITS-1:0] res_value_q;
  logic                  res_evict_q;
  logic [KEY_BITS-1:0]   res_key_q;

  logic                  out_valid_q;
  logic                  out_hit_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic                  out_evict_q;
  logic [KEY_BITS-1:0]   out_key_q;

  logic [ENT_W-1:0]      rd_raw;
  entry_t                rd_ent;
  entry_t                wr_ent;
  logic                  wr_en;
  logic                  eval_en;
  logic                  upd_en;
  logic                  evict_sel;
  logic                  out_load;
  logic                  s_fire;
  logic                  cfg_fire;
  logic [CAP_W-1:0]      cfg_cap;

  lkv_entry_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_raw),
    .wr_en_i   (wr_en),
    .wr_addr_i (chk_q),
    .wr_data_i (wr_ent)
  );

  assign rd_ent   = entry_t'(rd_raw);
  assign eval_en  = pend_q && ((state_q == ST_SCAN) || (state_q == ST_SCAN_TAIL));
  assign upd_en   = pend_q && ((state_q == ST_UPDATE) || (state_q == ST_UPDATE_TAIL));
  assign evict_sel = (req_put_q == REQ_PUT) && (occ_q >= cap_q) && worst_q;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    wr_ent = rd_ent;
    wr_en  = 1'b0;
    if (upd_en) begin
      if (chk_q == slot_q) begin
        wr_en       = 1'b1;
        wr_ent.rank = '0;
        if (req_put_q == REQ_PUT) begin
          wr_ent.key   = req_key_q;
          wr_ent.value = req_value_q;
        end
      end else if (valid_q[chk_q] && (age_all_q || (rd_ent.rank < old_rank_q))) begin
        wr_en       = 1'b1;
        wr_ent.rank = rd_ent.rank + RANK_W'(1);
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    priority if (cfg_data_i == '0) begin
      cfg_cap = CAP_W'(1);
    end else if (32'(cfg_data_i) > ENTRIES) begin
      cfg_cap = CAP_W'(ENTRIES);
    end else begin
      cfg_cap = CAP_W'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      chk_q       <= '0;
      pend_q      <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      cap_q       <= CAP_W'(CAP_RST);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_fire && (occ_q == '0)) begin
        cap_q <= cfg_cap;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            idx_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN, ST_UPDATE: begin
          pend_q <= 1'b1;
          chk_q  <= idx_q;
          if (idx_q == LAST_IDX) begin
            state_q <= (state_q == ST_SCAN) ? ST_SCAN_TAIL : ST_UPDATE_TAIL;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_SCAN_TAIL: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          idx_q  <= '0;
          pend_q <= 1'b0;
          if (hit_q || evict_sel) begin
            state_q <= ST_UPDATE;
          end else if ((req_put_q == REQ_PUT) && free_q) begin
            valid_q[free_slot_q] <= 1'b1;
            occ_q                <= occ_q + CAP_W'(1);
            state_q              <= ST_UPDATE;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_UPDATE_TAIL: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_put_q   <= s_axis_tuser;
      req_key_q   <= s_axis_tdata[KEY_BITS-1:0];
      req_value_q <= s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      worst_q     <= 1'b0;
    end
    if (eval_en) begin
      if (valid_q[chk_q] && (rd_ent.key == req_key_q) && !hit_q) begin
        hit_q       <= 1'b1;
        hit_slot_q  <= chk_q;
        hit_rank_q  <= rd_ent.rank;
        hit_value_q <= rd_ent.value;
      end
      if (!valid_q[chk_q] && !free_q) begin
        free_q      <= 1'b1;
        free_slot_q <= chk_q;
      end
      if (valid_q[chk_q] && (!worst_q || (rd_ent.rank > worst_rank_q))) begin
        worst_q      <= 1'b1;
        worst_slot_q <= chk_q;
        worst_rank_q <= rd_ent.rank;
        worst_key_q  <= rd_ent.key;
      end
    end
    if (state_q == ST_DECIDE) begin
      if (hit_q) begin
        res_hit_q   <= 1'b1;
        res_value_q <= (req_put_q == REQ_GET) ? hit_value_q : '0;
        res_evict_q <= 1'b0;
        res_key_q   <= '0;
        slot_q      <= hit_slot_q;
        old_rank_q  <= hit_rank_q;
        age_all_q   <= 1'b0;
      end else if (evict_sel) begin
        res_hit_q   <= 1'b0;
        res_value_q <= '0;
        res_evict_q <= 1'b1;
        res_key_q   <= worst_key_q;
        slot_q      <= worst_slot_q;
        old_rank_q  <= worst_rank_q;
        age_all_q   <= 1'b0;
      end else begin
        res_hit_q   <= 1'b0;
        res_value_q <= '0;
        res_evict_q <= 1'b0;
        res_key_q   <= '0;
        slot_q      <= free_slot_q;
        old_rank_q  <= '0;
        age_all_q   <= 1'b1;
      end
    end
    if (out_load) begin
      out_hit_q   <= res_hit_q;
      out_value_q <= res_value_q;
      out_evict_q <= res_evict_q;
      out_key_q   <= res_key_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_W'({out_key_q, out_value_q});
  assign m_axis_tuser  = {out_evict_q, out_hit_q};

endmodule

// ===== rtl/core/lkv_entry_ram.sv =====
// Entry store: one write port and one registered read port.
module lkv_entry_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
